// ===== src/mas_pkg.sv =====
// Shared constants and types for the moving average percent scaler.
`timescale 1ns / 1ps

package mas_pkg;

    localparam int SAMPLE_W   = 12;
    localparam int AVG8_W     = 15;
    localparam int PCT_W      = 10;
    localparam int NUM_W      = 22;
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;

    localparam logic [SAMPLE_W-1:0] DRY_RESET  = 12'd950;
    localparam logic [SAMPLE_W-1:0] WET_RESET  = 12'd200;
    localparam logic [PCT_W-1:0]    FULL_SCALE = 10'd1000;

    // Register index, taken from paddr bit 2.
    localparam logic REG_DRY = 1'b0;
    localparam logic REG_WET = 1'b1;

    typedef struct packed {
        logic [SAMPLE_W-1:0] dry;
        logic [SAMPLE_W-1:0] wet;
    } t_cfg;

    typedef struct packed {
        logic [PCT_W-1:0] pct;
        logic             err;
    } t_pct_res;

endpackage

// ===== src/mas_if.sv =====
// Request channel interfaces: sample input and result output.
`timescale 1ns / 1ps

interface mas_in_if;
    import mas_pkg::*;
    logic                valid;
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
    modport source (output valid, output sample, input ready);
    modport sink   (input valid, input sample, output ready);
endinterface

interface mas_out_if;
    import mas_pkg::*;
    logic              valid;
    logic              ready;
    logic [AVG8_W-1:0] average_eighths;
    logic [PCT_W-1:0]  percent_tenths;
    logic              config_error;
    modport source (output valid, output average_eighths, output percent_tenths,
                    output config_error, input ready);
    modport sink   (input valid, input average_eighths, input percent_tenths,
                    input config_error, output ready);
endinterface

// ===== src/mas_cfg_apb.sv =====
// APB register block holding the dry and wet levels.
`timescale 1ns / 1ps

module mas_cfg_apb (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [mas_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [mas_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [mas_pkg::APB_DATA_W-1:0]   prdata,
    output logic                             pready,
    output mas_pkg::t_cfg                    o_cfg
);
    import mas_pkg::*;

    t_cfg r_cfg;
    logic wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.dry <= DRY_RESET;
            r_cfg.wet <= WET_RESET;
        end else if (wr_en) begin
            case (paddr[2])
                REG_DRY: r_cfg.dry <= pwdata[SAMPLE_W-1:0];
                REG_WET: r_cfg.wet <= pwdata[SAMPLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            REG_DRY: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_cfg.dry};
            REG_WET: prdata = {{(APB_DATA_W-SAMPLE_W){1'b0}}, r_cfg.wet};
            default: prdata = '0;
        endcase
    end

endmodule

// ===== src/mas_window.sv =====
// Sample ring memory with running window sum (read, modify, write back).
`timescale 1ns / 1ps

module mas_window #(
    parameter int WINDOW_LENGTH = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mas_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_done,
    output logic [mas_pkg::SAMPLE_W-1:0]  o_avg,
    output logic [mas_pkg::AVG8_W-1:0]    o_avg8
);
    import mas_pkg::*;

    localparam int LOG2W = $clog2(WINDOW_LENGTH);
    localparam int SUM_W = SAMPLE_W + LOG2W;
    localparam logic [SUM_W-1:0] SUM_RESET = SUM_W'(WINDOW_LENGTH * 950);

    logic [SAMPLE_W-1:0]      mem [WINDOW_LENGTH];
    logic [WINDOW_LENGTH-1:0] r_valid;
    logic [LOG2W-1:0]         r_pos;
    logic [SUM_W-1:0]         r_sum;
    logic [SAMPLE_W-1:0]      r_rd_data;
    logic                     r_rd_vld;
    logic [SAMPLE_W-1:0]      r_sample;
    logic                     r_upd;
    logic                     r_done;
    logic [SAMPLE_W-1:0]      old_sample;

    // Entries never written read as the reset dry level.
    assign old_sample = r_rd_vld ? r_rd_data : DRY_RESET;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rd_data <= mem[r_pos];
            r_sample  <= i_sample;
        end
        if (r_upd) begin
            mem[r_pos] <= r_sample;
        end
    end

    // One request at a time: the write back lands before the next read.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid  <= '0;
            r_pos    <= '0;
            r_sum    <= SUM_RESET;
            r_rd_vld <= 1'b0;
            r_upd    <= 1'b0;
            r_done   <= 1'b0;
        end else begin
            r_upd  <= i_start;
            r_done <= r_upd;
            if (i_start) begin
                r_rd_vld <= r_valid[r_pos];
            end
            if (r_upd) begin
                r_sum          <= r_sum - SUM_W'(old_sample) + SUM_W'(r_sample);
                r_valid[r_pos] <= 1'b1;
                r_pos          <= r_pos + 1'b1;
            end
        end
    end

    assign o_done = r_done;
    assign o_avg  = r_sum[SUM_W-1:LOG2W];

    generate
        if (LOG2W == 3) begin : g_eq
            assign o_avg8 = r_sum;
        end else if (LOG2W < 3) begin : g_up
            assign o_avg8 = {r_sum, {(3-LOG2W){1'b0}}};
        end else begin : g_dn
            assign o_avg8 = r_sum[SUM_W-1:LOG2W-3];
        end
    endgenerate

endmodule

// ===== src/mas_pct_div.sv =====
// Clamp, scale by 1000 and restoring division for the wetness percentage.
`timescale 1ns / 1ps

module mas_pct_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [mas_pkg::SAMPLE_W-1:0]  i_avg,
    input  mas_pkg::t_cfg                 i_cfg,
    output logic                          o_done,
    output mas_pkg::t_pct_res             o_res
);
    import mas_pkg::*;

    typedef enum logic [3:0] {
        D_IDLE  = 4'b0001,
        D_CLAMP = 4'b0010,
        D_MUL   = 4'b0100,
        D_DIV   = 4'b1000
    } t_div_state;

    t_div_state          r_state;
    logic [SAMPLE_W-1:0] r_dry;
    logic [SAMPLE_W-1:0] r_wet;
    logic [SAMPLE_W-1:0] r_avg;
    logic [SAMPLE_W-1:0] r_diff;
    logic [SAMPLE_W-1:0] r_den;
    logic [NUM_W-1:0]    r_rem;
    logic [NUM_W-1:0]    r_dsh;
    logic [3:0]          r_cnt;
    logic [PCT_W-1:0]    r_quo;
    logic                r_err;
    logic                r_done;
    logic [SAMPLE_W-1:0] clamp_hi;
    logic [SAMPLE_W-1:0] clamped;
    logic                q_bit;

    assign clamp_hi = (r_avg > r_dry) ? r_dry : r_avg;
    assign clamped  = (clamp_hi < r_wet) ? r_wet : clamp_hi;
    assign q_bit    = (r_rem >= r_dsh);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
            r_done  <= 1'b0;
            r_err   <= 1'b0;
            r_quo   <= '0;
        end else begin
            r_done <= 1'b0;
            case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_dry   <= i_cfg.dry;
                        r_wet   <= i_cfg.wet;
                        r_avg   <= i_avg;
                        r_state <= D_CLAMP;
                    end
                end
                D_CLAMP: begin
                    if (r_dry > r_wet) begin
                        r_diff  <= r_dry - clamped;
                        r_den   <= r_dry - r_wet;
                        r_err   <= 1'b0;
                        r_state <= D_MUL;
                    end else begin
                        r_err   <= 1'b1;
                        r_quo   <= '0;
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                D_MUL: begin
                    // diff <= den, so the quotient fits in PCT_W bits
                    r_rem   <= {{(NUM_W-SAMPLE_W){1'b0}}, r_diff}
                               * {{(NUM_W-PCT_W){1'b0}}, FULL_SCALE};
                    r_dsh   <= {{(NUM_W-SAMPLE_W-PCT_W+1){1'b0}}, r_den,
                                {(PCT_W-1){1'b0}}};
                    r_cnt   <= 4'(PCT_W-1);
                    r_state <= D_DIV;
                end
                D_DIV: begin
                    if (q_bit) begin
                        r_rem <= r_rem - r_dsh;
                    end
                    r_dsh <= r_dsh >> 1;
                    r_quo <= {r_quo[PCT_W-2:0], q_bit};
                    r_cnt <= r_cnt - 1'b1;
                    if (r_cnt == '0) begin
                        r_done  <= 1'b1;
                        r_state <= D_IDLE;
                    end
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_done    = r_done;
    assign o_res.pct = r_quo;
    assign o_res.err = r_err;

endmodule

// ===== src/moving_average_percent_scaler.sv =====
// Top level: moving average of sensor samples with a wetness percentage.
`timescale 1ns / 1ps

// Each accepted sample replaces the oldest of WINDOW_LENGTH entries in a ring
// memory (one read, one write back) and updates a running window sum. The
// result gives the window average with three fraction bits and the wetness in
// tenths of a percent, (dry - clamped average) * 1000 / (dry - wet), truncated;
// when dry is not above wet the percentage is 0 and config_error is set. An
// item passes through the memory read-modify-write, then clamp and scaling,
// then the restoring divider (one quotient bit per cycle), and waits in S_OUT
// until the output register can take it. When dry is not above wet the divider
// is skipped. Memory entries carry valid bits cleared by reset, so no clearing
// pass is needed; unwritten entries read as 950. The output register lets a new
// sample be accepted while a result waits.
// Configure dry_level (0x0) and wet_level (0x4) over APB only while idle.
// WINDOW_LENGTH must be a power of two from 2 to 64.

module moving_average_percent_scaler #(
    parameter int WINDOW_LENGTH = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    mas_in_if.sink                         i_sample,
    mas_out_if.source                      o_result,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [mas_pkg::APB_ADDR_W-1:0] paddr,
    input  logic [mas_pkg::APB_DATA_W-1:0] pwdata,
    output logic [mas_pkg::APB_DATA_W-1:0] prdata,
    output logic                           pready
);
    import mas_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,   // waiting for a sample request
        S_WIN  = 4'b0010,   // ring memory read-modify-write
        S_PCT  = 4'b0100,   // percentage divider running
        S_OUT  = 4'b1000    // result ready, waiting for output register
    } t_ctl_state;

    t_ctl_state          r_state;
    t_cfg                cfg;
    t_pct_res            pct_res;
    logic                in_acc;
    logic                win_done;
    logic                div_done;
    logic [SAMPLE_W-1:0] avg;
    logic [AVG8_W-1:0]   avg8;
    logic                out_load;

    logic                r_out_valid;
    logic [AVG8_W-1:0]   r_out_avg8;
    logic [PCT_W-1:0]    r_out_pct;
    logic                r_out_err;

    mas_cfg_apb u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    mas_window #(
        .WINDOW_LENGTH (WINDOW_LENGTH)
    ) u_window (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (in_acc),
        .i_sample (i_sample.sample),
        .o_done   (win_done),
        .o_avg    (avg),
        .o_avg8   (avg8)
    );

    // Divider latches avg and cfg on start; both stay steady until then.
    mas_pct_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (win_done),
        .i_avg   (avg),
        .i_cfg   (cfg),
        .o_done  (div_done),
        .o_res   (pct_res)
    );

    assign i_sample.ready = (r_state == S_IDLE);
    assign in_acc         = i_sample.valid & i_sample.ready;
    // Load when the output register is empty or its request is taken now.
    assign out_load       = (r_state == S_OUT) & (~r_out_valid | o_result.ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            case (r_state)
                S_IDLE: if (in_acc)   r_state <= S_WIN;
                S_WIN:  if (win_done) r_state <= S_PCT;
                S_PCT:  if (div_done) r_state <= S_OUT;
                S_OUT:  if (out_load) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Sum is untouched until the next accept, so avg8 is still this item's.
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_avg8 <= avg8;
            r_out_pct  <= pct_res.pct;
            r_out_err  <= pct_res.err;
        end
    end

    assign o_result.valid           = r_out_valid;
    assign o_result.average_eighths = r_out_avg8;
    assign o_result.percent_tenths  = r_out_pct;
    assign o_result.config_error    = r_out_err;

    // ---- assertions ----
    a_win_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        win_done |-> (r_state == S_WIN))
        else $error("window update finished outside its state");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_PCT))
        else $error("divider finished outside its state");

    a_out_from_core: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_result.valid) |-> $past(r_state == S_OUT))
        else $error("result appeared without a finished item");

    a_err_zero_pct: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.config_error) |-> (o_result.percent_tenths == '0))
        else $error("config error with nonzero percentage");

    a_pct_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_result.valid |-> (o_result.percent_tenths <= FULL_SCALE))
        else $error("percentage above full scale");

endmodule

// ===== tb/moving_average_percent_scaler_tb.sv =====
// Testbench for the moving average percent scaler: directed table, then random samples.
`timescale 1ns / 1ps

module moving_average_percent_scaler_tb;
    import mas_pkg::*;

    localparam int WINDOW            = 8;
    localparam int POS_W             = $clog2(WINDOW);
    localparam int STALL_LIMIT       = 2000;  // cycles with no request moving anywhere
    localparam int SETTLE_CYCLES     = 20;    // extra wait after the last reading is back, before new levels
    localparam int DRAIN_CYCLES      = 40;
    localparam int ITEMS_PER_SETTING = 240;
    localparam int NUM_PHASES        = 4;
    localparam int NUM_FIXED_LEVELS  = 6;

    typedef struct packed {
        logic [AVG8_W-1:0] avg8;
        logic [PCT_W-1:0]  pct;
        logic              err;
    } t_reading;

    typedef struct packed {
        logic [SAMPLE_W-1:0] sample;
        logic                known;   // reading below is typed in, not predicted
        t_reading            reading;
    } t_vector;

    // Sender idle and receiver stall chances, in percent, per phase.
    localparam int IDLE_PLAN  [NUM_PHASES] = '{0, 64, 0, 32};
    localparam int STALL_PLAN [NUM_PHASES] = '{0, 0, 64, 32};

    // Level pairs: reset values, full span, inverted, equal, narrowest at both ends.
    localparam logic [SAMPLE_W-1:0] DRY_SET [NUM_FIXED_LEVELS] =
        '{DRY_RESET, 12'd4095, 12'd0, 12'd2000, 12'd1, 12'd4095};
    localparam logic [SAMPLE_W-1:0] WET_SET [NUM_FIXED_LEVELS] =
        '{WET_RESET, 12'd0, 12'd4095, 12'd2000, 12'd0, 12'd4094};

    // First row checks the reset window; then the window is filled with full
    // scale, zero (clamped to wet) and the midpoint between wet and dry.
    localparam t_vector DIRECTED_ROWS [25] = '{
        '{12'd950,  1'b1, '{15'd7600,  10'd0,    1'b0}},
        '{12'd4095, 1'b0, '0}, '{12'd4095, 1'b0, '0}, '{12'd4095, 1'b0, '0},
        '{12'd4095, 1'b0, '0}, '{12'd4095, 1'b0, '0}, '{12'd4095, 1'b0, '0},
        '{12'd4095, 1'b0, '0},
        '{12'd4095, 1'b1, '{15'd32760, 10'd0,    1'b0}},
        '{12'd0,    1'b0, '0}, '{12'd0,    1'b0, '0}, '{12'd0,    1'b0, '0},
        '{12'd0,    1'b0, '0}, '{12'd0,    1'b0, '0}, '{12'd0,    1'b0, '0},
        '{12'd0,    1'b0, '0},
        '{12'd0,    1'b1, '{15'd0,     10'd1000, 1'b0}},
        '{12'd575,  1'b0, '0}, '{12'd575,  1'b0, '0}, '{12'd575,  1'b0, '0},
        '{12'd575,  1'b0, '0}, '{12'd575,  1'b0, '0}, '{12'd575,  1'b0, '0},
        '{12'd575,  1'b0, '0},
        '{12'd575,  1'b1, '{15'd4600,  10'd500,  1'b0}}
    };

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mas_in_if  sample_ch ();
    mas_out_if result_ch ();

    moving_average_percent_scaler #(
        .WINDOW_LENGTH (WINDOW)
    ) dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_sample (sample_ch),
        .o_result (result_ch),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    // Predictor state: levels, sample window, write pointer and running total.
    logic [SAMPLE_W-1:0] dry_cfg;
    logic [SAMPLE_W-1:0] wet_cfg;
    logic [SAMPLE_W-1:0] window_mem [WINDOW];
    logic [POS_W-1:0]    wr_pos;
    int unsigned         window_total;

    t_reading pending_readings [$];
    int       error_count  = 0;
    int       quiet_cycles = 0;
    int       idle_pct     = 0;
    int       stall_pct    = 0;
    logic     cur_known    = 1'b0;
    t_reading cur_reading  = '0;

    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Push a sample into the window and work out the reading it yields.
    function automatic t_reading scale_sample(input logic [SAMPLE_W-1:0] s);
        t_reading    r;
        int unsigned mean;
        int unsigned clamped;
        window_total       = window_total - window_mem[wr_pos] + s;
        window_mem[wr_pos] = s;
        wr_pos             = wr_pos + 1'b1;  // wraps, depth is a power of two
        mean               = window_total / WINDOW;
        r.avg8             = AVG8_W'((window_total * 8) / WINDOW);
        r.pct              = '0;
        r.err              = 1'b0;
        if (dry_cfg > wet_cfg) begin
            clamped = (mean > dry_cfg) ? dry_cfg : mean;
            if (clamped < wet_cfg) begin
                clamped = wet_cfg;
            end
            r.pct = PCT_W'(((dry_cfg - clamped) * FULL_SCALE) / (dry_cfg - wet_cfg));
        end else begin
            r.err = 1'b1;
        end
        return r;
    endfunction

    // Uniform random samples, samples around the wet..dry span, some rails, some repeats.
    function automatic logic [SAMPLE_W-1:0] pick_sample(input logic [SAMPLE_W-1:0] last);
        int k;
        int lo;
        int hi;
        k  = $urandom_range(99);
        lo = ((dry_cfg < wet_cfg) ? dry_cfg : wet_cfg) - 60;
        hi = ((dry_cfg > wet_cfg) ? dry_cfg : wet_cfg) + 60;
        if (lo < 0) begin
            lo = 0;
        end
        if (hi > 4095) begin
            hi = 4095;
        end
        if (k < 40) begin
            return SAMPLE_W'($urandom_range(4095));
        end else if (k < 70) begin
            return SAMPLE_W'($urandom_range(hi, lo));
        end else if (k < 85) begin
            return $urandom_range(1) ? 12'd4095 : 12'd0;
        end
        return last;
    endfunction

    // Scoreboard: results are checked before new requests are predicted.
    always @(posedge i_clk) begin
        t_reading want;
        t_reading got;
        logic     moved;
        if (i_rst_n) begin
            moved = psel && penable;
            if (result_ch.valid && result_ch.ready) begin
                moved = 1'b1;
                got   = {result_ch.average_eighths, result_ch.percent_tenths,
                         result_ch.config_error};
                if (pending_readings.size() == 0) begin
                    $display("%0t: unexpected result avg8=%0d pct=%0d err=%0d",
                             $time, got.avg8, got.pct, got.err);
                    error_count++;
                end else begin
                    want = pending_readings.pop_front();
                    if (got !== want) begin
                        $display({"%0t: mismatch expected avg8=%0d pct=%0d err=%0d, ",
                                  "got avg8=%0d pct=%0d err=%0d"},
                                 $time, want.avg8, want.pct, want.err,
                                 got.avg8, got.pct, got.err);
                        error_count++;
                    end
                end
            end
            if (sample_ch.valid && sample_ch.ready) begin
                moved = 1'b1;
                want  = scale_sample(sample_ch.sample);
                pending_readings.push_back(cur_known ? cur_reading : want);
            end
            quiet_cycles = moved ? 0 : quiet_cycles + 1;
        end
    end

    // Result receiver: stalls at random at the rate of the current phase.
    always @(negedge i_clk) begin
        result_ch.ready = ($urandom_range(99) >= stall_pct);
    end

    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input logic known,
                               input t_reading r);
        while ($urandom_range(99) < idle_pct) begin
            sample_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        sample_ch.valid  = 1'b1;
        sample_ch.sample = s;
        cur_known        = known;
        cur_reading      = r;
        do @(posedge i_clk); while (!sample_ch.ready);
        @(negedge i_clk);
    endtask

    // Hold off new requests until every reading is back, then wait a while.
    task automatic drain_requests(input int extra);
        sample_ch.valid = 1'b0;
        while (pending_readings.size() != 0) begin
            @(negedge i_clk);
        end
        repeat (extra) @(negedge i_clk);
    endtask

    // Junk in the upper data bits must be dropped by the register.
    task automatic write_level(input logic idx, input logic [SAMPLE_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {idx, 2'b00};
        pwdata  = {20'($urandom), value};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
        if (idx == REG_DRY) begin
            dry_cfg = value;
        end else begin
            wet_cfg = value;
        end
    endtask

    task automatic check_level(input logic idx, input logic [SAMPLE_W-1:0] want);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b0;
        paddr   = {idx, 2'b00};
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata !== APB_DATA_W'(want)) begin
            $display("%0t: register %0d readback expected %0d, got %0d",
                     $time, idx, want, prdata);
            error_count++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    task automatic set_levels(input logic [SAMPLE_W-1:0] dry,
                              input logic [SAMPLE_W-1:0] wet);
        drain_requests(SETTLE_CYCLES);
        write_level(REG_DRY, dry);
        write_level(REG_WET, wet);
        check_level(REG_DRY, dry);
        check_level(REG_WET, wet);
    endtask

    initial begin : watchdog
        do @(posedge i_clk); while (quiet_cycles < STALL_LIMIT);
        $display("CHECK FAILED");
        $finish;
    end

    initial begin
        logic [SAMPLE_W-1:0] last;
        int                  k;
        i_rst_n          = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        sample_ch.valid  = 1'b0;
        sample_ch.sample = '0;
        result_ch.ready  = 1'b0;
        dry_cfg          = DRY_RESET;
        wet_cfg          = WET_RESET;
        foreach (window_mem[i]) begin
            window_mem[i] = DRY_RESET;
        end
        wr_pos       = '0;
        window_total = WINDOW * DRY_RESET;
        last         = DRY_RESET;

        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (DIRECTED_ROWS[i]) begin
            send_sample(DIRECTED_ROWS[i].sample, DIRECTED_ROWS[i].known,
                        DIRECTED_ROWS[i].reading);
        end

        for (int ph = 0; ph < NUM_PHASES; ph++) begin
            idle_pct  = IDLE_PLAN[ph];
            stall_pct = STALL_PLAN[ph];
            for (int j = 0; j < 2; j++) begin
                k = ph * 2 + j;
                if (k < NUM_FIXED_LEVELS) begin
                    set_levels(DRY_SET[k], WET_SET[k]);
                end else begin
                    set_levels(SAMPLE_W'($urandom_range(4095)),
                               SAMPLE_W'($urandom_range(4095)));
                end
                for (int n = 0; n < ITEMS_PER_SETTING; n++) begin
                    // Once per phase the sender waits for the pipe to run dry.
                    if (j == 0 && n == ITEMS_PER_SETTING / 2) begin
                        drain_requests(0);
                    end
                    last = pick_sample(last);
                    send_sample(last, 1'b0, '0);
                end
            end
        end

        drain_requests(DRAIN_CYCLES);
        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule

// ===== moving_average_percent_scaler.f =====
src/mas_pkg.sv
src/mas_if.sv
src/mas_cfg_apb.sv
src/mas_window.sv
src/mas_pct_div.sv
src/moving_average_percent_scaler.sv
tb/moving_average_percent_scaler_tb.sv
